// ===== rtl/htu_pkg.sv =====
package htu_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DIM       = 4;
  localparam int MAT_N     = DIM * DIM;
  localparam int DATA_W    = 32;
  localparam int IDX_W     = $clog2(DIM);
  // one operand carries a negated sine, so it needs an extra bit
  localparam int OPND_W    = DATA_W + 1;
  localparam int PROD_W    = DATA_W + OPND_W;
  localparam int SH_W      = PROD_W - FRAC_BITS;
  localparam int ACC_W     = SH_W + IDX_W;

  localparam logic [3:0] OP_IDENT  = 4'd0;
  localparam logic [3:0] OP_WRITE  = 4'd1;
  localparam logic [3:0] OP_READ   = 4'd2;
  localparam logic [3:0] OP_SCALE  = 4'd3;
  localparam logic [3:0] OP_TRANSL = 4'd4;
  localparam logic [3:0] OP_SCALAR = 4'd5;
  localparam logic [3:0] OP_ROTX   = 4'd6;
  localparam logic [3:0] OP_ROTY   = 4'd7;
  localparam logic [3:0] OP_ROTZ   = 4'd8;
  localparam logic [3:0] OP_XFORM  = 4'd9;

  typedef logic signed [DATA_W-1:0] q_t;
  typedef logic signed [SH_W-1:0]   prod_t;
  typedef logic signed [ACC_W-1:0]  acc_t;

  localparam q_t Q_ONE = q_t'(DATA_W'(1) << FRAC_BITS);
  localparam q_t Q_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam q_t Q_MIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic [IDX_W-1:0] LAST_COL = IDX_W'(DIM - 1);

  typedef struct packed {
    logic [3:0]       op;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    q_t               val_a;
    q_t               val_b;
    q_t               val_c;
    q_t               val_d;
  } item_t;

  // Rotation touches columns p and q; lane u and the last lane carry the cross terms.
  typedef struct packed {
    logic [IDX_W-1:0] p;
    logic [IDX_W-1:0] q;
    logic [IDX_W-1:0] u;
    logic             y_axis;
  } rot_sel_t;

  function automatic rot_sel_t rot_decode(input logic [3:0] op);
    rot_sel_t rs;
    rs.y_axis = 1'b0;
    case (op)
      OP_ROTX: begin
        rs.p = IDX_W'(1);
        rs.q = IDX_W'(2);
        rs.u = IDX_W'(0);
      end
      OP_ROTY: begin
        rs.p = IDX_W'(0);
        rs.q = IDX_W'(2);
        rs.u = IDX_W'(1);
        rs.y_axis = 1'b1;
      end
      default: begin
        rs.p = IDX_W'(0);
        rs.q = IDX_W'(1);
        rs.u = IDX_W'(2);
      end
    endcase
    return rs;
  endfunction

  function automatic q_t ident_elem(input int idx);
    return ((idx / DIM) == (idx % DIM)) ? Q_ONE : '0;
  endfunction

  function automatic q_t sat_q(input acc_t v);
    q_t r;
    if (v[ACC_W-1:DATA_W-1] == '0 || v[ACC_W-1:DATA_W-1] == '1) begin
      r = v[DATA_W-1:0];
    end else if (v[ACC_W-1]) begin
      r = Q_MIN;
    end else begin
      r = Q_MAX;
    end
    return r;
  endfunction

  function automatic logic writes_matrix(input logic [3:0] op);
    return (op <= OP_ROTZ) && (op != OP_READ);
  endfunction

  function automatic logic has_result(input logic [3:0] op);
    return (op == OP_READ) || (op == OP_XFORM);
  endfunction

endpackage

// ===== rtl/homogeneous_transform_unit_top.sv =====
// 4x4 Q16.16 transform unit. One transaction is accepted per clock while
// nothing holds the pipeline. A vector transform or element read passes the
// input and product registers before its result is registered at the output,
// and back-to-back transforms stream at one per cycle unless the output stalls.
// The rate is set by the bank of sixteen 32x33 multipliers, which has a
// register on each side. Any operation that changes the matrix (identity,
// write, scale, translate, scalar, rotate) holds the next transaction back from
// the multipliers until the matrix is updated. The matrix resets to identity.
module homogeneous_transform_unit_top import htu_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [3:0]  in_op,
  input  logic [1:0]  in_row,
  input  logic [1:0]  in_col,
  input  logic signed [31:0] in_val_a,
  input  logic signed [31:0] in_val_b,
  input  logic signed [31:0] in_val_c,
  input  logic signed [31:0] in_val_d,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [31:0] out_res_x,
  output logic signed [31:0] out_res_y,
  output logic signed [31:0] out_res_z,
  output logic signed [31:0] out_res_w
);

  logic  a_valid_r;
  item_t a_item_r;
  logic  b_valid_r;
  item_t b_item_r;
  prod_t b_prod_r [MAT_N];
  prod_t prod     [MAT_N];
  q_t    mat      [MAT_N];
  logic  out_valid_r;
  q_t    res_r    [DIM];
  q_t    res_nxt  [DIM];
  acc_t  acc      [DIM];
  logic  in_fire;
  logic  a_adv;
  logic  b_adv;
  logic  b_res;

  assign b_res   = has_result(b_item_r.op);
  assign b_adv   = b_valid_r && (!b_res || !out_valid_r || out_ready);
  // hold the next transaction while a matrix update is still in flight
  assign a_adv   = a_valid_r && (!b_valid_r || b_adv) &&
                   !(b_valid_r && writes_matrix(b_item_r.op));
  assign in_ready = !a_valid_r || a_adv;
  assign in_fire  = in_valid && in_ready;

  htu_mac_lanes u_lanes (
    .item (a_item_r),
    .mat  (mat),
    .prod (prod)
  );

  htu_matrix u_matrix (
    .clk    (clk),
    .rst_n  (rst_n),
    .upd_en (b_adv && writes_matrix(b_item_r.op)),
    .item   (b_item_r),
    .prod   (b_prod_r),
    .mat    (mat)
  );

  always_comb begin
    for (int j = 0; j < DIM; j++) begin
      acc[j] = '0;
      for (int k = 0; k < DIM; k++) begin
        acc[j] = acc[j] + acc_t'(b_prod_r[k * DIM + j]);
      end
      res_nxt[j] = sat_q(acc[j]);
    end
    if (b_item_r.op == OP_READ) begin
      res_nxt[0] = mat[{b_item_r.row, b_item_r.col}];
      for (int j = 1; j < DIM; j++) begin
        res_nxt[j] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      b_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      a_valid_r   <= (a_valid_r && !a_adv) || in_fire;
      b_valid_r   <= (b_valid_r && !b_adv) || a_adv;
      out_valid_r <= (out_valid_r && !out_ready) || (b_adv && b_res);
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      a_item_r <= '{op: in_op, row: in_row, col: in_col, val_a: in_val_a,
                    val_b: in_val_b, val_c: in_val_c, val_d: in_val_d};
    end
    if (a_adv) begin
      b_item_r <= a_item_r;
      b_prod_r <= prod;
    end
    if (b_adv && b_res) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res_x = res_r[0];
  assign out_res_y = res_r[1];
  assign out_res_z = res_r[2];
  assign out_res_w = res_r[3];

endmodule

// ===== rtl/htu_mac_lanes.sv =====
module htu_mac_lanes import htu_pkg::*; (
  input  item_t item,
  input  q_t    mat  [MAT_N],
  output prod_t prod [MAT_N]
);

  rot_sel_t                 rs;
  logic signed [OPND_W-1:0] s_ext;
  logic signed [OPND_W-1:0] ns_ext;
  logic signed [OPND_W-1:0] c_ext;
  logic signed [OPND_W-1:0] sp;
  logic signed [OPND_W-1:0] sq;
  logic signed [OPND_W-1:0] vec   [DIM];
  q_t                       mcand [MAT_N];
  logic signed [OPND_W-1:0] opnd  [MAT_N];
  logic signed [PROD_W-1:0] full  [MAT_N];
  logic [IDX_W-1:0]         lr    [MAT_N];
  logic [IDX_W-1:0]         lc    [MAT_N];

  always_comb begin
    rs     = rot_decode(item.op);
    s_ext  = {item.val_a[DATA_W-1], item.val_a};
    ns_ext = -s_ext;
    c_ext  = {item.val_b[DATA_W-1], item.val_b};
    sp     = rs.y_axis ? s_ext : ns_ext;
    sq     = rs.y_axis ? ns_ext : s_ext;
    vec[0] = s_ext;
    vec[1] = c_ext;
    vec[2] = {item.val_c[DATA_W-1], item.val_c};
    vec[3] = {item.val_d[DATA_W-1], item.val_d};

    for (int i = 0; i < MAT_N; i++) begin
      lr[i]    = IDX_W'(i / DIM);
      lc[i]    = IDX_W'(i % DIM);
      mcand[i] = mat[i];
      opnd[i]  = s_ext;
      case (item.op) inside
        // lane (k,j) weighs M[k][j] by vector component k; scale uses the diagonal lanes
        OP_XFORM, OP_SCALE: opnd[i] = vec[lr[i]];
        OP_ROTX, OP_ROTY, OP_ROTZ: begin
          if (lc[i] == rs.p || lc[i] == rs.q) begin
            opnd[i] = c_ext;
          end else if (lc[i] == rs.u) begin
            mcand[i] = mat[{lr[i], rs.q}];
            opnd[i]  = sp;
          end else begin
            mcand[i] = mat[{lr[i], rs.p}];
            opnd[i]  = sq;
          end
        end
        default: ;
      endcase
      full[i] = mcand[i] * opnd[i];
      // arithmetic shift: floor toward minus infinity
      prod[i] = full[i][PROD_W-1:FRAC_BITS];
    end
  end

endmodule

// ===== rtl/htu_matrix.sv =====
module htu_matrix import htu_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  upd_en,
  input  item_t item,
  input  prod_t prod [MAT_N],
  output q_t    mat  [MAT_N]
);

  localparam int T0 = (DIM - 1) * DIM;

  q_t               mat_r   [MAT_N];
  q_t               mat_nxt [MAT_N];
  rot_sel_t         rs;
  logic [IDX_W-1:0] lr;

  always_comb begin
    mat_nxt = mat_r;
    rs      = rot_decode(item.op);
    lr      = '0;
    case (item.op) inside
      OP_IDENT: begin
        for (int i = 0; i < MAT_N; i++) begin
          mat_nxt[i] = ident_elem(i);
        end
      end
      OP_WRITE: mat_nxt[{item.row, item.col}] = item.val_a;
      OP_SCALE: begin
        for (int y = 0; y < DIM - 1; y++) begin
          mat_nxt[y * DIM + y] = sat_q(acc_t'(prod[y * DIM + y]));
        end
      end
      OP_TRANSL: begin
        mat_nxt[T0]     = sat_q(acc_t'(mat_r[T0])     + acc_t'(item.val_a));
        mat_nxt[T0 + 1] = sat_q(acc_t'(mat_r[T0 + 1]) + acc_t'(item.val_b));
        mat_nxt[T0 + 2] = sat_q(acc_t'(mat_r[T0 + 2]) + acc_t'(item.val_c));
      end
      OP_SCALAR: begin
        for (int i = 0; i < MAT_N; i++) begin
          mat_nxt[i] = sat_q(acc_t'(prod[i]));
        end
      end
      OP_ROTX, OP_ROTY, OP_ROTZ: begin
        for (int y = 0; y < DIM; y++) begin
          lr = IDX_W'(y);
          mat_nxt[{lr, rs.p}] = sat_q(acc_t'(prod[{lr, rs.p}]) + acc_t'(prod[{lr, rs.u}]));
          mat_nxt[{lr, rs.q}] = sat_q(acc_t'(prod[{lr, rs.q}]) + acc_t'(prod[{lr, LAST_COL}]));
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAT_N; i++) begin
        mat_r[i] <= ident_elem(i);
      end
    end else if (upd_en) begin
      mat_r <= mat_nxt;
    end
  end

  assign mat = mat_r;

endmodule

// ===== rtl/htu_checker.sv =====
module htu_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_res_x,
  input logic [31:0] out_res_y,
  input logic [31:0] out_res_z,
  input logic [31:0] out_res_w
);

  // a stalled result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_res_x) && $stable(out_res_y) &&
                                $stable(out_res_z) && $stable(out_res_w))
    else $error("result dropped or changed while stalled");

  // reset empties the pipeline
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("pipeline not empty after reset");

  // with the output side idle and no new transactions, the pipe drains and in_ready returns
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid && $past(!out_valid) && $past(!out_valid, 2) &&
    $past(!(in_valid && in_ready)) && $past(!(in_valid && in_ready), 2) |-> in_ready)
    else $error("input stalled with nothing pending downstream");

endmodule

bind homogeneous_transform_unit_top htu_checker u_htu_checker (.*);

// ===== tb/sv/homogeneous_transform_unit_top_tb.sv =====
`timescale 1ns / 100ps

module homogeneous_transform_unit_top_tb import htu_pkg::*;;

  localparam logic [3:0] OP_FIRST_UNUSED = 4'd10;
  localparam logic [3:0] OP_LAST_UNUSED  = 4'd15;
  localparam int RAND_ITEMS = 1350;
  localparam int CYC_LIMIT  = 300000;
  localparam int QUIET_LO   = 2000;
  localparam int QUIET_HI   = 3500;
  localparam int HOLD_AT    = 300;
  localparam int HOLD_LEN   = 400;
  localparam int DRAIN_CYC  = 8;

  typedef struct {
    q_t x;
    q_t y;
    q_t z;
    q_t w;
  } vec_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [3:0] in_op = '0;
  logic [1:0] in_row = '0;
  logic [1:0] in_col = '0;
  logic signed [31:0] in_val_a = '0;
  logic signed [31:0] in_val_b = '0;
  logic signed [31:0] in_val_c = '0;
  logic signed [31:0] in_val_d = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] out_res_x;
  logic signed [31:0] out_res_y;
  logic signed [31:0] out_res_z;
  logic signed [31:0] out_res_w;

  item_t stim_q[$];
  vec_t  res_due[$];
  longint xform_mat [MAT_N];
  int unsigned cyc = 0;
  int errors = 0;
  int res_seen = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  homogeneous_transform_unit_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_op     (in_op),
    .in_row    (in_row),
    .in_col    (in_col),
    .in_val_a  (in_val_a),
    .in_val_b  (in_val_b),
    .in_val_c  (in_val_c),
    .in_val_d  (in_val_d),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res_x (out_res_x),
    .out_res_y (out_res_y),
    .out_res_z (out_res_z),
    .out_res_w (out_res_w)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc == CYC_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------- matrix predictor ----------------

  function automatic longint qmul(input longint a, input longint b);
    return (a * b) >>> FRAC_BITS;
  endfunction

  function automatic longint sat32(input longint v);
    if (v > longint'(Q_MAX)) return longint'(Q_MAX);
    if (v < longint'(Q_MIN)) return longint'(Q_MIN);
    return v;
  endfunction

  function automatic void load_identity();
    for (int i = 0; i < MAT_N; i++)
      xform_mat[i] = (i / DIM == i % DIM) ? longint'(Q_ONE) : 64'sd0;
  endfunction

  function automatic void rotate_matrix(input logic [3:0] op, input q_t s, input q_t c);
    longint rot [MAT_N];
    longint nxt [MAT_N];
    longint acc;
    for (int i = 0; i < MAT_N; i++)
      rot[i] = (i / DIM == i % DIM) ? longint'(Q_ONE) : 64'sd0;
    case (op)
      OP_ROTX: begin
        rot[1*DIM+1] = c;
        rot[1*DIM+2] = s;
        rot[2*DIM+1] = -longint'(s);
        rot[2*DIM+2] = c;
      end
      OP_ROTY: begin
        rot[0*DIM+0] = c;
        rot[0*DIM+2] = -longint'(s);
        rot[2*DIM+0] = s;
        rot[2*DIM+2] = c;
      end
      default: begin
        rot[0*DIM+0] = c;
        rot[0*DIM+1] = s;
        rot[1*DIM+0] = -longint'(s);
        rot[1*DIM+1] = c;
      end
    endcase
    // every element comes from the old matrix
    for (int y = 0; y < DIM; y++) begin
      for (int x = 0; x < DIM; x++) begin
        acc = 0;
        for (int k = 0; k < DIM; k++)
          acc += qmul(xform_mat[y*DIM+k], rot[k*DIM+x]);
        nxt[y*DIM+x] = sat32(acc);
      end
    end
    xform_mat = nxt;
  endfunction

  function automatic void apply_op(input item_t it);
    vec_t   r;
    longint v [DIM];
    longint acc [DIM];
    case (it.op)
      OP_IDENT: load_identity();
      OP_WRITE: xform_mat[it.row*DIM+it.col] = longint'(it.val_a);
      OP_READ: begin
        r.x = q_t'(xform_mat[it.row*DIM+it.col]);
        r.y = '0;
        r.z = '0;
        r.w = '0;
        res_due.push_back(r);
      end
      OP_SCALE: begin
        xform_mat[0] = sat32(qmul(xform_mat[0], it.val_a));
        xform_mat[1*DIM+1] = sat32(qmul(xform_mat[1*DIM+1], it.val_b));
        xform_mat[2*DIM+2] = sat32(qmul(xform_mat[2*DIM+2], it.val_c));
      end
      OP_TRANSL: begin
        xform_mat[3*DIM+0] = sat32(xform_mat[3*DIM+0] + longint'(it.val_a));
        xform_mat[3*DIM+1] = sat32(xform_mat[3*DIM+1] + longint'(it.val_b));
        xform_mat[3*DIM+2] = sat32(xform_mat[3*DIM+2] + longint'(it.val_c));
      end
      OP_SCALAR: begin
        for (int i = 0; i < MAT_N; i++)
          xform_mat[i] = sat32(qmul(xform_mat[i], it.val_a));
      end
      OP_ROTX, OP_ROTY, OP_ROTZ: rotate_matrix(it.op, it.val_a, it.val_b);
      OP_XFORM: begin
        v[0] = it.val_a;
        v[1] = it.val_b;
        v[2] = it.val_c;
        v[3] = it.val_d;
        for (int j = 0; j < DIM; j++) begin
          acc[j] = 0;
          for (int i = 0; i < DIM; i++)
            acc[j] += qmul(xform_mat[i*DIM+j], v[i]);
        end
        r.x = q_t'(sat32(acc[0]));
        r.y = q_t'(sat32(acc[1]));
        r.z = q_t'(sat32(acc[2]));
        r.w = q_t'(sat32(acc[3]));
        res_due.push_back(r);
      end
      default: ;
    endcase
  endfunction

  // ---------------- stimulus helpers ----------------

  function automatic bit idle_pick();
    if (cyc >= QUIET_LO && cyc < QUIET_HI) return 1'b0;
    return $urandom_range(99) < 12;
  endfunction

  function automatic void add_item(input logic [3:0] op, input int row, input int col,
                                   input q_t a, input q_t b, input q_t c, input q_t d);
    item_t it;
    it.op = op;
    it.row = row[1:0];
    it.col = col[1:0];
    it.val_a = a;
    it.val_b = b;
    it.val_c = c;
    it.val_d = d;
    stim_q.push_back(it);
  endfunction

  function automatic q_t rand_q();
    int unsigned pick;
    pick = $urandom_range(9);
    if (pick <= 5) return q_t'(int'($urandom_range(0, 1 << 19)) - (1 << 18));
    if (pick <= 7) return q_t'($urandom);
    if (pick == 8) begin
      case ($urandom_range(4))
        0: return Q_MAX;
        1: return Q_MIN;
        2: return Q_ONE;
        3: return -Q_ONE;
        default: return '0;
      endcase
    end
    return q_t'(int'($urandom_range(0, 1 << 18)) - (1 << 17));
  endfunction

  // mostly within +-2.0: keeps the matrix from collapsing or saturating too fast
  function automatic q_t rand_unitish();
    if ($urandom_range(7) == 0) return rand_q();
    return q_t'(int'($urandom_range(0, 1 << 18)) - (1 << 17));
  endfunction

  // ---------------- driver ----------------

  always @(posedge clk) begin
    item_t cur;
    item_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        cur.op = in_op;
        cur.row = in_row;
        cur.col = in_col;
        cur.val_a = in_val_a;
        cur.val_b = in_val_b;
        cur.val_c = in_val_c;
        cur.val_d = in_val_d;
        apply_op(cur);
      end
      if (!in_valid || in_ready) begin
        if (stim_q.size() != 0 && !idle_pick()) begin
          nxt = stim_q.pop_front();
          in_op <= nxt.op;
          in_row <= nxt.row;
          in_col <= nxt.col;
          in_val_a <= nxt.val_a;
          in_val_b <= nxt.val_b;
          in_val_c <= nxt.val_c;
          in_val_d <= nxt.val_d;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------- monitor ----------------

  function automatic void check_field(input string name, input q_t want, input q_t got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    vec_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        res_seen++;
        if (res_due.size() == 0) begin
          $display("%0t: unexpected transaction, expected none, got %0d %0d %0d %0d",
                   $time, out_res_x, out_res_y, out_res_z, out_res_w);
          errors++;
        end else begin
          want = res_due.pop_front();
          check_field("res_x", want.x, out_res_x);
          check_field("res_y", want.y, out_res_y);
          check_field("res_z", want.z, out_res_z);
          check_field("res_w", want.w, out_res_w);
        end
      end
      // one long hold-off lets the pipeline back up into the input side
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (!hold_done && res_seen >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_LEN;
        out_ready <= 1'b0;
      end else begin
        out_ready <= !idle_pick();
      end
    end
  end

  // ---------------- sequence ----------------

  initial begin
    int made;
    int unsigned pick;

    // identity readback
    add_item(OP_READ, 0, 0, '0, '0, '0, '0);
    add_item(OP_READ, 3, 3, '0, '0, '0, '0);
    add_item(OP_READ, 1, 2, '0, '0, '0, '0);
    add_item(OP_XFORM, 0, 0, Q_ONE, -Q_ONE, Q_MAX, Q_MIN);
    // extreme element values, then overflow of the sums
    add_item(OP_WRITE, 3, 3, Q_MAX, '0, '0, '0);
    add_item(OP_WRITE, 0, 0, Q_MIN, '0, '0, '0);
    add_item(OP_WRITE, 2, 1, 32'sh1234_5678, '0, '0, '0);
    add_item(OP_XFORM, 0, 0, Q_MAX, Q_MAX, Q_MAX, Q_MAX);
    add_item(OP_XFORM, 0, 0, Q_MIN, Q_MIN, Q_MIN, Q_MIN);
    add_item(OP_READ, 3, 3, '0, '0, '0, '0);
    add_item(OP_READ, 0, 0, '0, '0, '0, '0);
    add_item(OP_IDENT, 0, 0, '0, '0, '0, '0);
    add_item(OP_SCALE, 0, 0, 32'sh0002_0000, -32'sh0000_8000, Q_MAX, '0);
    add_item(OP_TRANSL, 0, 0, Q_MAX, Q_MIN, 32'sh0001_8000, '0);
    add_item(OP_TRANSL, 0, 0, Q_MAX, Q_MIN, 32'sh0001_8000, '0);
    add_item(OP_SCALAR, 0, 0, Q_MIN, '0, '0, '0);
    add_item(OP_XFORM, 0, 0, Q_ONE, Q_ONE, Q_ONE, Q_ONE);
    add_item(OP_IDENT, 0, 0, '0, '0, '0, '0);
    // unnormalized rotation: most negative sine, so its negation needs 33 bits
    add_item(OP_ROTX, 0, 0, Q_MIN, Q_MAX, '0, '0);
    add_item(OP_ROTY, 0, 0, 32'sh0000_8000, 32'sh0000_DDB4, '0, '0);
    add_item(OP_ROTZ, 0, 0, Q_ONE, '0, '0, '0);
    add_item(OP_XFORM, 0, 0, 32'sh0003_0000, -32'sh0002_0000, Q_ONE, Q_ONE);
    // unused codes leave the matrix alone
    add_item(OP_LAST_UNUSED, 2, 2, Q_MIN, Q_MIN, Q_MIN, Q_MIN);
    add_item(OP_FIRST_UNUSED, 1, 1, Q_MAX, Q_MAX, Q_MAX, Q_MAX);
    add_item(OP_READ, 2, 2, '0, '0, '0, '0);

    made = 0;
    while (made < RAND_ITEMS) begin
      pick = $urandom_range(99);
      made++;
      if (pick < 50)
        add_item(OP_XFORM, 0, 0, rand_q(), rand_q(), rand_q(), rand_q());
      else if (pick < 62)
        add_item(OP_READ, $urandom_range(3), $urandom_range(3), rand_q(), rand_q(),
                 rand_q(), rand_q());
      else if (pick < 70)
        add_item(OP_WRITE, $urandom_range(3), $urandom_range(3), rand_q(), rand_q(),
                 rand_q(), rand_q());
      else if (pick < 74)
        add_item(OP_SCALE, $urandom_range(3), $urandom_range(3), rand_unitish(),
                 rand_unitish(), rand_unitish(), rand_q());
      else if (pick < 78)
        add_item(OP_TRANSL, $urandom_range(3), $urandom_range(3), rand_q(), rand_q(),
                 rand_q(), rand_q());
      else if (pick < 81)
        add_item(OP_SCALAR, $urandom_range(3), $urandom_range(3), rand_unitish(),
                 rand_q(), rand_q(), rand_q());
      else if (pick < 84)
        add_item(OP_ROTX, 0, 0, rand_unitish(), rand_unitish(), rand_q(), rand_q());
      else if (pick < 87)
        add_item(OP_ROTY, 0, 0, rand_unitish(), rand_unitish(), rand_q(), rand_q());
      else if (pick < 90)
        add_item(OP_ROTZ, 0, 0, rand_unitish(), rand_unitish(), rand_q(), rand_q());
      else if (pick < 94)
        add_item(OP_IDENT, $urandom_range(3), $urandom_range(3), rand_q(), rand_q(),
                 rand_q(), rand_q());
      else begin
        // ignored transactions do not count
        made--;
        add_item(4'($urandom_range(OP_LAST_UNUSED, OP_FIRST_UNUSED)), $urandom_range(3),
                 $urandom_range(3), rand_q(), rand_q(), rand_q(), rand_q());
      end
    end

    load_identity();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    while (stim_q.size() != 0 || in_valid) @(posedge clk);
    while (res_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);

    if (errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== homogeneous_transform_unit_top.f =====
rtl/htu_pkg.sv
rtl/htu_mac_lanes.sv
rtl/htu_matrix.sv
rtl/homogeneous_transform_unit_top.sv
rtl/htu_checker.sv
tb/sv/homogeneous_transform_unit_top_tb.sv
